// ----- src/tcma_pkg.sv -----
package tcma_pkg;

    localparam int SLOT_BITS   = 3;
    localparam int WINDOW      = 1 << SLOT_BITS;
    localparam int SAMPLE_BITS = 12;
    localparam int NUM_CH      = 4;
    localparam int SUM_BITS    = SAMPLE_BITS + SLOT_BITS;
    localparam int WORD_BITS   = NUM_CH * SAMPLE_BITS;

    localparam int CH_Z1 = 2;

    localparam logic [SAMPLE_BITS-1:0] THRESH_RESET = SAMPLE_BITS'(50);

    typedef logic [SAMPLE_BITS-1:0]             sample_t;
    typedef logic [SUM_BITS-1:0]                sum_t;
    typedef logic [SLOT_BITS-1:0]               slot_t;
    typedef logic [NUM_CH-1:0][SAMPLE_BITS-1:0] set_t;

    typedef struct packed {
        set_t fresh;
        set_t old;
    } upd_t;

endpackage

// ----- src/tcma_ram.sv -----
module tcma_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/tcma_accum.sv -----
module tcma_accum (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  tcma_pkg::upd_t                  in_upd,
    input  tcma_pkg::sample_t               threshold,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tcma_pkg::WORD_BITS-1:0]  out_data,
    output logic                            out_touched
);

    tcma_pkg::sum_t sum_reg  [tcma_pkg::NUM_CH];
    tcma_pkg::sum_t sum_next [tcma_pkg::NUM_CH];
    tcma_pkg::set_t mean_next;
    tcma_pkg::set_t mean_reg;
    logic           touched_next;
    logic           touched_reg;
    logic           out_valid_reg;
    logic           take;

    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        for (int i = 0; i < tcma_pkg::NUM_CH; i++)
        begin
            sum_next[i]  = tcma_pkg::sum_t'(sum_reg[i] - tcma_pkg::sum_t'(in_upd.old[i])
                                           + tcma_pkg::sum_t'(in_upd.fresh[i]));
            mean_next[i] = sum_next[i][tcma_pkg::SUM_BITS-1:tcma_pkg::SLOT_BITS];
        end
        touched_next = mean_next[tcma_pkg::CH_Z1] > threshold;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < tcma_pkg::NUM_CH; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            if (take)
            begin
                out_valid_reg <= 1'b1;
                for (int i = 0; i < tcma_pkg::NUM_CH; i++)
                begin
                    sum_reg[i] <= sum_next[i];
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mean_reg    <= mean_next;
            touched_reg <= touched_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_data    = mean_reg;
    assign out_touched = touched_reg;

endmodule

// ----- src/touch_channel_moving_average_top.sv -----
// eight-sample boxcar average over four touch channels (x, y, z1, z2)
// input stream s_axis: one word holds one set of four raw 12-bit samples
// output stream m_axis: one word holds the four averages, tuser flags a touch
// cfg channel: writes the 12-bit touch threshold (reset value 50), always ready
// a touch is flagged when the z1 average is strictly above the threshold
// the sample rings live in one 48-bit x 8 synchronous ram, read at acceptance
// and written back when the word leaves the read stage; running sums are held in flops
// a word accepted on s_axis is registered in the read stage, then in the accumulator, before it shows on m_axis
// throughput: one word per cycle while m_axis_tready is high, set by the single ram read and write port pair
// a held output word does not block intake: one more word waits in the
// read stage, after which s_axis_tready drops until m_axis_tready returns
// reset clears the sums, the write slot and the per-entry valid bits, so
// unwritten ring entries read as zero and the first seven averages ramp up
// no clearing pass is needed: words are accepted right after reset
module touch_channel_moving_average_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // sample_x, sample_y, sample_z1, sample_z2
    input  logic [tcma_pkg::WORD_BITS-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // mean_x, mean_y, mean_z1, mean_z2
    output logic [tcma_pkg::WORD_BITS-1:0] m_axis_tdata,
    // is_touched
    output logic                           m_axis_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tcma_pkg::SAMPLE_BITS-1:0] cfg_data
);

    tcma_pkg::sample_t         thresh_reg;
    tcma_pkg::slot_t           slot_reg;
    tcma_pkg::slot_t           s1_slot_reg;
    logic                      s1_valid_reg;
    logic                      s1_old_ok_reg;
    tcma_pkg::set_t            s1_fresh_reg;
    logic [tcma_pkg::WINDOW-1:0] entry_ok_reg;
    logic [tcma_pkg::WORD_BITS-1:0] ram_rdata;
    tcma_pkg::upd_t            upd;
    logic                      s1_ready;
    logic                      accept;
    logic                      s1_take;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !s1_valid_reg || s1_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s1_take       = s1_valid_reg && s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= tcma_pkg::THRESH_RESET;
        end
        else if (cfg_valid)
        begin
            thresh_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg     <= '0;
            s1_valid_reg <= 1'b0;
            entry_ok_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                slot_reg     <= tcma_pkg::slot_t'(slot_reg + 1'b1);
                s1_valid_reg <= 1'b1;
            end
            else if (s1_ready)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_take)
            begin
                entry_ok_reg[s1_slot_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_slot_reg   <= slot_reg;
            s1_fresh_reg  <= s_axis_tdata;
            s1_old_ok_reg <= entry_ok_reg[slot_reg];
        end
    end

    tcma_ram #(
        .WIDTH (tcma_pkg::WORD_BITS),
        .DEPTH (tcma_pkg::WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (s1_take),
        .waddr (s1_slot_reg),
        .wdata (s1_fresh_reg),
        .re    (accept),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // entries never written count as zero
    assign upd.fresh = s1_fresh_reg;
    assign upd.old   = s1_old_ok_reg ? tcma_pkg::set_t'(ram_rdata) : '0;

    tcma_accum u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s1_valid_reg),
        .in_ready    (s1_ready),
        .in_upd      (upd),
        .threshold   (thresh_reg),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata),
        .out_touched (m_axis_tuser)
    );

`ifndef SYNTH
    a_no_same_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s1_take) |-> (slot_reg != s1_slot_reg))
        else $error("ring read and write hit the same slot");

    a_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted word lost before the read stage");

    a_slot_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (slot_reg == tcma_pkg::slot_t'($past(slot_reg) + 1'b1)))
        else $error("write slot did not advance by one");

    a_slot_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(slot_reg))
        else $error("write slot moved without a word");
`endif

endmodule

// ----- sim/tb_touch_channel_moving_average_top.sv -----
module tb_touch_channel_moving_average_top;

    import tcma_pkg::*;

    typedef struct packed {
        logic touched;
        set_t means;
    } mean_set_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [WORD_BITS-1:0]   s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [WORD_BITS-1:0]   m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [SAMPLE_BITS-1:0] cfg_data;

    // running-average predictor state
    sample_t ring_m [NUM_CH][WINDOW];
    sum_t    sum_m [NUM_CH];
    slot_t   slot_m;
    sample_t thresh_m;

    mean_set_t mean_q [$];
    int        errors;
    string     chan_name [NUM_CH] = '{"x", "y", "z1", "z2"};

    // sender and receiver pacing
    int unsigned burst_left;
    int unsigned gap_max;
    int unsigned rx_mode;
    int unsigned hold_request;
    int unsigned hold_left;
    logic [7:0]  rx_pattern;

    touch_channel_moving_average_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic mean_set_t boxcar_step(input set_t raw);
        mean_set_t r;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            sum_m[ch] = sum_m[ch] - ring_m[ch][slot_m] + raw[ch];
            ring_m[ch][slot_m] = raw[ch];
            r.means[ch] = sample_t'(sum_m[ch] >> SLOT_BITS);
        end
        r.touched = r.means[CH_Z1] > thresh_m;
        slot_m = slot_m + 1'b1;
        return r;
    endfunction

    function automatic sample_t pick_extreme();
        case ($urandom_range(0, 2))
            0: return '0;
            1: return '1;
            default: return sample_t'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic set_t random_set();
        set_t raw;
        int   v;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                for (int ch = 0; ch < NUM_CH; ch++)
                    raw[ch] = pick_extreme();
            end
            2, 3, 4:
            begin
                // pressure hovering around the threshold
                for (int ch = 0; ch < NUM_CH; ch++)
                    raw[ch] = sample_t'($urandom_range(0, 4095));
                v = int'(thresh_m) + int'($urandom_range(0, 80)) - 40;
                if (v < 0)
                    v = 0;
                if (v > 4095)
                    v = 4095;
                raw[CH_Z1] = sample_t'(v);
            end
            default:
            begin
                for (int ch = 0; ch < NUM_CH; ch++)
                    raw[ch] = sample_t'($urandom_range(0, 4095));
            end
        endcase
        return raw;
    endfunction

    // checker and predictor
    always @(posedge clk)
    begin
        mean_set_t got;
        mean_set_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.means   = m_axis_tdata;
                got.touched = m_axis_tuser;
                if (mean_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word, expected none, actual %h touched %0d",
                             $time, got.means, got.touched);
                end
                else
                begin
                    want = mean_q.pop_front();
                    for (int ch = 0; ch < NUM_CH; ch++)
                    begin
                        if (got.means[ch] !== want.means[ch])
                        begin
                            errors++;
                            $display("%0t: mean_%s expected %0d actual %0d", $time,
                                     chan_name[ch], want.means[ch], got.means[ch]);
                        end
                    end
                    if (got.touched !== want.touched)
                    begin
                        errors++;
                        $display("%0t: is_touched expected %0d actual %0d",
                                 $time, want.touched, got.touched);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                thresh_m = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                mean_q.push_back(boxcar_step(s_axis_tdata));
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready = 1'b0;
        end
        else
        begin
            case (rx_mode)
                0: m_axis_tready = 1'b1;
                1: m_axis_tready = ($urandom_range(0, 3) != 0);
                2:
                begin
                    rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
                    m_axis_tready = rx_pattern[0];
                end
                default: m_axis_tready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic send_word(input set_t raw);
        int unsigned gap;
        s_axis_tdata  = raw;
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(0, 15);
        end
    endtask

    task automatic send_same(input sample_t x, input sample_t y, input sample_t z1,
                             input sample_t z2, input int unsigned count);
        set_t raw;
        raw[0] = x;
        raw[1] = y;
        raw[2] = z1;
        raw[3] = z2;
        repeat (count) send_word(raw);
    endtask

    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        burst_left    = 0;
        while (mean_q.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_threshold(input sample_t value);
        cfg_data  = value;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic test_startup_ramp();
        gap_max = 2;
        rx_mode = 1;
        // first z1 average equals the reset threshold, then climbs past it
        send_same(12'hFFF, 12'hAAA, 12'd400, 12'h555, 9);
        wait_idle();
    endtask

    task automatic test_field_extremes();
        gap_max = 0;
        rx_mode = 0;
        send_same('1, '1, '1, '1, 8);
        send_same('0, '0, '0, '0, 4);
        wait_idle();
    endtask

    task automatic test_threshold_extremes();
        write_threshold('0);
        send_same(12'h001, 12'h800, 12'h000, 12'h7FF, 2);
        wait_idle();
        write_threshold('1);
        send_same('1, '1, '1, '1, 2);
        wait_idle();
    endtask

    task automatic test_backpressure();
        gap_max = 0;
        rx_mode = 0;
        hold_request = 64;
        repeat (24) send_word(random_set());
        wait_idle();
    endtask

    task automatic test_random_stream();
        sample_t thr [6];
        int unsigned gaps [6] = '{0, 3, 8, 1, 5, 2};
        thr[0] = sample_t'($urandom_range(0, 4095));
        thr[1] = '0;
        thr[2] = '1;
        thr[3] = sample_t'($urandom_range(0, 4095));
        thr[4] = sample_t'($urandom_range(1900, 2200));
        thr[5] = THRESH_RESET;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_threshold(thr[ph]);
            gap_max = gaps[ph];
            rx_mode = (ph == 0) ? 0 : ph % 4;
            repeat (250) send_word(random_set());
            wait_idle();
        end
    endtask

    initial
    begin
        errors        = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        burst_left    = 0;
        gap_max       = 0;
        rx_mode       = 0;
        hold_request  = 0;
        hold_left     = 0;
        rx_pattern    = 8'b1101_1010;
        thresh_m      = THRESH_RESET;
        slot_m        = '0;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            sum_m[ch] = '0;
            for (int k = 0; k < WINDOW; k++)
                ring_m[ch][k] = '0;
        end
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_startup_ramp();
        test_field_extremes();
        test_threshold_extremes();
        test_backpressure();
        test_random_stream();

        repeat (4) @(negedge clk);
        if (errors == 0)
            $display("** touch_channel_moving_average_top: PASSED **");
        else
            $display("** touch_channel_moving_average_top: FAILED **");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("** touch_channel_moving_average_top: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
src/tcma_pkg.sv
src/tcma_ram.sv
src/tcma_accum.sv
src/touch_channel_moving_average_top.sv
sim/tb_touch_channel_moving_average_top.sv
